### rtl/core/sequence_gap_tracker_unit_assert.svh
// Assertion macros shared by the sequence gap tracker RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SEQUENCE_GAP_TRACKER_UNIT_ASSERT_SVH
`define SEQUENCE_GAP_TRACKER_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SGT_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SGT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define SGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sgt_pkg.sv
// Shared types and constants of the sequence gap tracker.
// Used by sgt_cell and sequence_gap_tracker_unit; depends on nothing.
package sgt_pkg;

  // Field widths of the stream payloads.
  localparam int SEQ_IN_W    = 31;
  localparam int SKIP_W      = 5;
  localparam int CODE_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CODE_W - 2 * SEQ_IN_W;

  // Request kinds carried on in_tuser.
  localparam logic OP_TRACK = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  // Result codes.
  localparam logic [CODE_W-1:0] CODE_IN_SEQ     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_REPLAYED   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GAP_CLOSED = 3'd2;
  localparam logic [CODE_W-1:0] CODE_NEW_GAP    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_FULL       = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift;  // every cell takes its neighbor's block
    logic wr;     // the addressed cell loads the write block
  } cell_ctl_t;

endpackage

### rtl/core/sgt_cell.sv
// One storage cell of the block chain: holds a single [begin, end) range.
// Depends on sgt_pkg for the control struct.
module sgt_cell #(
  parameter int SEQ_BITS = 32,
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  sgt_pkg::cell_ctl_t    ctl,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [SEQ_BITS-1:0]   wr_begin,
  input  logic [SEQ_BITS-1:0]   wr_end,
  input  logic [SEQ_BITS-1:0]   nbr_begin,
  input  logic [SEQ_BITS-1:0]   nbr_end,
  output logic [SEQ_BITS-1:0]   begin_q,
  output logic [SEQ_BITS-1:0]   end_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SEQ_BITS-1:0] begin_r;
  logic [SEQ_BITS-1:0] end_r;

  // A direct write wins over the shift, so the tail slot can take the
  // block leaving the head in the same cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == MY_IDX)) begin
      begin_r <= wr_begin;
      end_r   <= wr_end;
    end else if (ctl.shift) begin
      begin_r <= nbr_begin;
      end_r   <= nbr_end;
    end
  end

  assign begin_q = begin_r;
  assign end_q   = end_r;

endmodule

### rtl/core/sequence_gap_tracker_unit.sv
// Sequence gap tracker: ordered table of received [begin, end) blocks in a chain of cells.
// Requests are taken one at a time: in_tready is high only in the idle state, and each
// request walks all N stored blocks (at most MAX_BLOCKS), one block per cycle past the head
// cell unless an insertion holds the head in place, before its result is registered.
// Reset (synchronous, rst_n low) empties the table and drops any pending result.
// Depends on sgt_pkg, sgt_cell and sequence_gap_tracker_unit_assert.svh.
`include "sequence_gap_tracker_unit_assert.svh"

module sequence_gap_tracker_unit #(
  parameter int MAX_BLOCKS = 16,
  parameter int SEQ_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sgt_pkg::IN_TDATA_W-1:0]     in_tdata,   // seq[30:0], skip[35:31], zero pad
  input  logic                               in_tuser,   // op
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sgt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // code[2:0], gap_begin[33:3],
                                                         // gap_end[64:34], zero pad
  output logic                               out_tuser   // found
);

  // The table lives in a row of cells that works as a queue. Block j of the
  // ordered table sits in cell 0 when j blocks have been walked; cell 1 then
  // holds block j + 1. Each walk step pops the head and writes it, possibly
  // modified, back at the tail slot, so after N steps the table is in its
  // original order again. Inserting a block before the head is a tail write
  // without a pop, which places the new block between the walked blocks and
  // the rest. Appending is a tail write once the walk is over.

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = $clog2(MAX_BLOCKS);

  localparam logic [CNT_W-1:0]    MAX_CNT  = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]    CNT_ONE  = CNT_W'(1);
  localparam logic [SEQ_BITS-1:0] SEQ_ONE  = SEQ_BITS'(1);
  localparam logic [SEQ_BITS-1:0] SEQ_ZERO = '0;
  localparam logic [sgt_pkg::SKIP_W-1:0] SKIP_ONE = {{(sgt_pkg::SKIP_W-1){1'b0}}, 1'b1};

  // Unpacked request fields.
  logic [sgt_pkg::SEQ_IN_W-1:0] in_seq;
  logic [sgt_pkg::SKIP_W-1:0]   in_skip;
  logic [SEQ_BITS-1:0]          in_seq_s;

  assign in_seq  = in_tdata[sgt_pkg::SEQ_IN_W-1:0];
  assign in_skip = in_tdata[sgt_pkg::SEQ_IN_W +: sgt_pkg::SKIP_W];

  // Sequence numbers are held modulo 2^SEQ_BITS.
  generate
    if (SEQ_BITS > sgt_pkg::SEQ_IN_W) begin : g_seq_wide
      assign in_seq_s = {{(SEQ_BITS - sgt_pkg::SEQ_IN_W){1'b0}}, in_seq};
    end else begin : g_seq_narrow
      assign in_seq_s = in_seq[SEQ_BITS-1:0];
    end
  endgenerate

  // Control registers.
  sgt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;     // blocks in the table
  logic [CNT_W-1:0] rem_r;       // blocks still to walk past the head
  logic             done_r;      // the request has been decided during the walk
  logic             prev_valid_r;
  logic             out_tvalid_r;

  // Request and result payload registers.
  logic                         op_r;
  logic [SEQ_BITS-1:0]          s_r;
  logic [sgt_pkg::SKIP_W-1:0]   skip_r;
  logic [SEQ_BITS-1:0]          prev_end_r; // end of the previous block; 1 before the first
  logic [sgt_pkg::CODE_W-1:0]   code_r;
  logic                         found_r;
  logic [SEQ_BITS-1:0]          gb_r;
  logic [SEQ_BITS-1:0]          ge_r;
  logic [sgt_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                         out_tuser_r;

  // Chain of cells.
  logic [SEQ_BITS-1:0] cell_begin [MAX_BLOCKS];
  logic [SEQ_BITS-1:0] cell_end   [MAX_BLOCKS];
  sgt_pkg::cell_ctl_t  cell_ctl;
  logic [IDX_W-1:0]    wr_idx_c;
  logic [SEQ_BITS-1:0] wr_begin_c;
  logic [SEQ_BITS-1:0] wr_end_c;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
      localparam int NBR = (gi + 1) % MAX_BLOCKS;
      sgt_cell #(
        .SEQ_BITS (SEQ_BITS),
        .IDX_W    (IDX_W),
        .CELL_IDX (gi)
      ) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .wr_idx    (wr_idx_c),
        .wr_begin  (wr_begin_c),
        .wr_end    (wr_end_c),
        .nbr_begin (cell_begin[NBR]),
        .nbr_end   (cell_end[NBR]),
        .begin_q   (cell_begin[gi]),
        .end_q     (cell_end[gi])
      );
    end
  endgenerate

  // Head of the queue and its successor.
  logic [SEQ_BITS-1:0] head_b;
  logic [SEQ_BITS-1:0] head_e;
  logic [SEQ_BITS-1:0] next_b;
  logic [SEQ_BITS-1:0] head_e_inc;
  logic [SEQ_BITS-1:0] s_inc;
  logic [CNT_W-1:0]    cnt_m1;

  assign head_b     = cell_begin[0];
  assign head_e     = cell_end[0];
  assign next_b     = cell_begin[1];
  assign head_e_inc = head_e + SEQ_ONE;
  assign s_inc      = s_r + SEQ_ONE;
  assign cnt_m1     = count_r - CNT_ONE;

  // Walk and finish decisions.
  logic                       accept_c;
  logic                       pop_c;
  logic                       ins_c;
  logic                       app_c;
  logic                       decide_c;
  logic                       hit_c;
  logic                       skip_dec_c;
  logic                       out_free_c;
  logic                       finish_c;
  logic [sgt_pkg::CODE_W-1:0] code_c;
  logic [sgt_pkg::CODE_W-1:0] fin_code_c;
  logic [SEQ_BITS-1:0]        wb_c;
  logic [SEQ_BITS-1:0]        we_c;

  assign accept_c   = in_tvalid && in_tready;
  assign out_free_c = !out_tvalid_r || out_tready;
  assign finish_c   = (state_r == sgt_pkg::S_DONE) && out_free_c;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = sgt_pkg::S_WALK;
      end
      sgt_pkg::S_WALK: begin
        if (rem_r == '0) state_nxt = sgt_pkg::S_DONE;
      end
      sgt_pkg::S_DONE: begin
        if (out_free_c) state_nxt = sgt_pkg::S_IDLE;
      end
      default: state_nxt = sgt_pkg::S_IDLE;
    endcase
  end

  // Walk step: look at the head block and decide what the request does with
  // it. Once the request is decided, the remaining blocks just cycle through
  // unchanged so that the table comes back into order.
  always_comb begin
    pop_c      = 1'b0;
    ins_c      = 1'b0;
    decide_c   = 1'b0;
    hit_c      = 1'b0;
    skip_dec_c = 1'b0;
    code_c     = code_r;
    wb_c       = head_b;
    we_c       = head_e;
    if ((state_r == sgt_pkg::S_WALK) && (rem_r != '0)) begin
      pop_c = 1'b1;
      if (!done_r) begin
        if (op_r == sgt_pkg::OP_TRACK) begin
          if (s_r == head_e) begin
            // Extending a block at its end. With a later block, the end may
            // only grow up to that block's begin.
            decide_c = 1'b1;
            if (rem_r > CNT_ONE) begin
              code_c = sgt_pkg::CODE_REPLAYED;
              if (head_e < next_b) begin
                we_c = head_e_inc;
                if (head_e_inc >= next_b) code_c = sgt_pkg::CODE_GAP_CLOSED;
              end
            end else begin
              we_c   = head_e_inc;
              code_c = sgt_pkg::CODE_IN_SEQ;
            end
          end else if ((s_r >= head_b) && (s_r < head_e)) begin
            decide_c = 1'b1;
            code_c   = sgt_pkg::CODE_REPLAYED;
          end else if ((head_b != SEQ_ZERO) && (s_r == head_b - SEQ_ONE)) begin
            // Extending a block at its beginning.
            decide_c = 1'b1;
            wb_c     = s_r;
            if ((s_r == SEQ_ONE) || (prev_valid_r && (prev_end_r >= s_r))) begin
              code_c = sgt_pkg::CODE_GAP_CLOSED;
            end else begin
              code_c = sgt_pkg::CODE_REPLAYED;
            end
          end else if (s_r < head_b) begin
            // A new one-number block goes in before the head unless the table is full. The head stays
            // put this cycle and the new block lands at the tail.
            decide_c = 1'b1;
            if (count_r == MAX_CNT) begin
              code_c = sgt_pkg::CODE_FULL;
            end else begin
              pop_c  = 1'b0;
              ins_c  = 1'b1;
              wb_c   = s_r;
              we_c   = s_inc;
              code_c = sgt_pkg::CODE_REPLAYED;
            end
          end
        end else begin
          // Find gap: a hole lies between the previous end and this begin.
          if (head_b > prev_end_r) begin
            if (skip_r != '0) begin
              skip_dec_c = 1'b1;
            end else begin
              decide_c = 1'b1;
              hit_c    = 1'b1;
            end
          end
        end
      end
    end
  end

  // Finish: a track request that matched no block appends one at the end if the table has room.
  always_comb begin
    app_c      = 1'b0;
    fin_code_c = code_r;
    if ((op_r == sgt_pkg::OP_TRACK) && !done_r) begin
      if (count_r == MAX_CNT) begin
        fin_code_c = sgt_pkg::CODE_FULL;
      end else begin
        app_c      = finish_c;
        fin_code_c = (s_r == SEQ_ONE) ? sgt_pkg::CODE_IN_SEQ : sgt_pkg::CODE_NEW_GAP;
      end
    end
  end

  // Chain write port: a popped head goes to the last occupied slot, an
  // inserted or appended block to the first free one.
  always_comb begin
    cell_ctl.shift = pop_c;
    cell_ctl.wr    = pop_c || ins_c || app_c;
    wr_idx_c       = (ins_c || app_c) ? count_r[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
    wr_begin_c     = app_c ? s_r : wb_c;
    wr_end_c       = app_c ? s_inc : we_c;
  end

  // Gap bounds are reported in 31 bits.
  logic [sgt_pkg::SEQ_IN_W-1:0] gb_out;
  logic [sgt_pkg::SEQ_IN_W-1:0] ge_out;

  generate
    if (SEQ_BITS >= sgt_pkg::SEQ_IN_W) begin : g_out_cut
      assign gb_out = gb_r[sgt_pkg::SEQ_IN_W-1:0];
      assign ge_out = ge_r[sgt_pkg::SEQ_IN_W-1:0];
    end else begin : g_out_ext
      assign gb_out = {{(sgt_pkg::SEQ_IN_W - SEQ_BITS){1'b0}}, gb_r};
      assign ge_out = {{(sgt_pkg::SEQ_IN_W - SEQ_BITS){1'b0}}, ge_r};
    end
  endgenerate

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sgt_pkg::S_IDLE;
      count_r      <= '0;
      rem_r        <= '0;
      done_r       <= 1'b0;
      prev_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept_c) begin
        rem_r        <= count_r;
        done_r       <= 1'b0;
        prev_valid_r <= 1'b0;
      end
      if (pop_c) begin
        rem_r        <= rem_r - CNT_ONE;
        prev_valid_r <= 1'b1;
      end
      if (decide_c) done_r <= 1'b1;
      if (ins_c || app_c) count_r <= count_r + CNT_ONE;
      if (finish_c) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept_c) begin
      op_r       <= in_tuser;
      s_r        <= in_seq_s;
      skip_r     <= in_skip;
      prev_end_r <= SEQ_ONE;
      code_r     <= sgt_pkg::CODE_IN_SEQ;
      found_r    <= 1'b0;
      gb_r       <= SEQ_ZERO;
      ge_r       <= SEQ_ZERO;
    end
    if (pop_c) prev_end_r <= head_e;
    if (skip_dec_c) skip_r <= skip_r - SKIP_ONE;
    if (decide_c) code_r <= code_c;
    if (hit_c) begin
      found_r <= 1'b1;
      gb_r    <= prev_end_r;
      ge_r    <= head_b;
    end
    if (finish_c) begin
      out_tdata_r <= {{sgt_pkg::OUT_PAD_W{1'b0}}, ge_out, gb_out, fin_code_c};
      out_tuser_r <= found_r;
    end
  end

  assign in_tready  = (state_r == sgt_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The table never holds more blocks than it has cells.
  `SGT_ASSERT_HOLDS(a_count_bound, count_r <= MAX_CNT, "block count above table size")
  // An insertion needs a free cell at the tail.
  `SGT_ASSERT_IMPL(a_insert_room, ins_c, count_r != MAX_CNT, "insert into a full table")
  // The walk never has more blocks left than the table holds.
  `SGT_ASSERT_IMPL(a_rem_bound, state_r == sgt_pkg::S_WALK, rem_r <= count_r,
                   "walk counter beyond block count")
  // A finished walk always moves on to deliver its result.
  `SGT_ASSERT_NEXT(a_walk_ends, (state_r == sgt_pkg::S_WALK) && (rem_r == '0),
                   state_r == sgt_pkg::S_DONE, "walk did not finish")

endmodule
